@@ rtl/ofa_pkg.sv @@
// Shared types and constants for the optical-flow frame accumulator.
package ofa_pkg;

    localparam int FRAME_LEN = 9;
    localparam int CNT_W     = $clog2(FRAME_LEN + 2);
    localparam int POS_W     = 32;
    localparam int DX_W      = 17;
    localparam int DY_W      = 16;
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;

    localparam logic [7:0] HEADER_BYTE = 8'hFE;
    localparam logic [7:0] TAIL_BYTE   = 8'hAA;
    localparam logic [7:0] QUAL_RESET  = 8'd30;
    localparam logic       INVX_RESET  = 1'b1;

    // Register index, taken from paddr[2].
    localparam logic REG_QUAL = 1'b0;
    localparam logic REG_INVX = 1'b1;

    typedef enum logic [1:0] {
        CMD_BYTE  = 2'd0,
        CMD_EOF   = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_NONE      = 3'd0,
        ST_OK        = 3'd1,
        ST_BAD_FRAME = 3'd2,
        ST_BAD_SUM   = 3'd3,
        ST_LOW_QUAL  = 3'd4
    } t_status;

    typedef logic [FRAME_LEN-1:0][7:0] t_frame;

    typedef struct packed {
        t_status                 status;
        logic                    accept;
        logic signed [DX_W-1:0]  dx;
        logic signed [DY_W-1:0]  dy;
    } t_check_res;

endpackage

@@ rtl/optical_flow_frame_accumulator_core.sv @@
// Top level: input register, frame store and check, position accumulators, result register.
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  in      | i_in_valid, o_in_ready, i_cmd, i_data_byte | request in
//  out     | o_out_valid, i_out_ready, o_pos_x, o_pos_y,| result out
//          | o_delta_x, o_delta_y, o_status             |
//  cfg     | psel, penable, pwrite, paddr, pwdata,      | APB
//          | prdata, pready                             |
//
// One request per cycle while no stalled result holds the core.
// Stage one is the input register; the frame check and the 32-bit position add
// sit between it and the result register and update state as the request moves on.
// Synchronous active-low reset clears control, counter, positions and deltas.
// A stalled result holds both stages; o_in_ready stays high while stage one can drain.
module optical_flow_frame_accumulator_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [1:0]                         i_cmd,
    input  logic [7:0]                         i_data_byte,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic signed [ofa_pkg::POS_W-1:0]   o_pos_x,
    output logic signed [ofa_pkg::POS_W-1:0]   o_pos_y,
    output logic signed [ofa_pkg::DX_W-1:0]    o_delta_x,
    output logic signed [ofa_pkg::DY_W-1:0]    o_delta_y,
    output logic [2:0]                         o_status,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [ofa_pkg::PADDR_W-1:0]        paddr,
    input  logic [ofa_pkg::PDATA_W-1:0]        pwdata,
    output logic [ofa_pkg::PDATA_W-1:0]        prdata,
    output logic                               pready
);
    import ofa_pkg::*;

    logic              r_in_valid;
    t_cmd              r_cmd;
    logic [7:0]        r_byte;
    logic              r_out_valid;
    logic [POS_W-1:0]  r_pos_x, r_pos_y, n_pos_x, n_pos_y;
    logic [DX_W-1:0]   r_dx, n_dx;
    logic [DY_W-1:0]   r_dy, n_dy;
    logic [POS_W-1:0]  r_out_x, r_out_y;
    logic [DX_W-1:0]   r_out_dx;
    logic [DY_W-1:0]   r_out_dy;
    t_status           r_out_status, n_status;

    logic              advance, process, do_wr, do_eof, do_clear;
    logic [7:0]        qual_thr;
    logic              invert_x;
    t_frame            frame;
    logic              full;
    t_check_res        chk;

    assign advance    = !r_out_valid || i_out_ready;
    assign o_in_ready = !r_in_valid || advance;
    assign process    = r_in_valid && advance;
    assign do_wr      = process && (r_cmd == CMD_BYTE);
    assign do_eof     = process && (r_cmd == CMD_EOF);
    assign do_clear   = process && (r_cmd == CMD_CLEAR);

    ofa_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .o_qual_thr (qual_thr),
        .o_invert_x (invert_x)
    );

    ofa_frame_buf u_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (do_wr),
        .i_eof   (do_eof),
        .i_byte  (r_byte),
        .o_frame (frame),
        .o_full  (full)
    );

    ofa_frame_check u_chk (
        .i_frame    (frame),
        .i_full     (full),
        .i_qual_thr (qual_thr),
        .i_invert_x (invert_x),
        .o_res      (chk)
    );

    always_comb begin
        n_pos_x  = r_pos_x;
        n_pos_y  = r_pos_y;
        n_dx     = r_dx;
        n_dy     = r_dy;
        n_status = ST_NONE;
        if (do_clear) begin
            n_pos_x = '0;
            n_pos_y = '0;
        end else if (do_eof) begin
            n_status = chk.status;
            if (chk.accept) begin
                n_dx    = chk.dx;
                n_dy    = chk.dy;
                n_pos_x = r_pos_x + {{(POS_W-DX_W){chk.dx[DX_W-1]}}, chk.dx};
                n_pos_y = r_pos_y + {{(POS_W-DY_W){chk.dy[DY_W-1]}}, chk.dy};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_pos_x     <= '0;
            r_pos_y     <= '0;
            r_dx        <= '0;
            r_dy        <= '0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
            if (process) begin
                r_pos_x <= n_pos_x;
                r_pos_y <= n_pos_y;
                r_dx    <= n_dx;
                r_dy    <= n_dy;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_cmd  <= t_cmd'(i_cmd);
            r_byte <= i_data_byte;
        end
        if (process) begin
            r_out_x      <= n_pos_x;
            r_out_y      <= n_pos_y;
            r_out_dx     <= n_dx;
            r_out_dy     <= n_dy;
            r_out_status <= n_status;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_pos_x     = r_out_x;
    assign o_pos_y     = r_out_y;
    assign o_delta_x   = r_out_dx;
    assign o_delta_y   = r_out_dy;
    assign o_status    = r_out_status;

endmodule

@@ rtl/ofa_cfg_regs.sv @@
// APB configuration registers: quality threshold and x inversion.
module ofa_cfg_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ofa_pkg::PADDR_W-1:0] paddr,
    input  logic [ofa_pkg::PDATA_W-1:0] pwdata,
    output logic [ofa_pkg::PDATA_W-1:0] prdata,
    output logic                        pready,
    output logic [7:0]                  o_qual_thr,
    output logic                        o_invert_x
);
    import ofa_pkg::*;

    logic [7:0] r_qual_thr;
    logic       r_invert_x;
    logic       wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qual_thr <= QUAL_RESET;
            r_invert_x <= INVX_RESET;
        end else if (wr_en) begin
            if (paddr[2] == REG_QUAL) begin
                r_qual_thr <= pwdata[7:0];
            end else begin
                r_invert_x <= pwdata[0];
            end
        end
    end

    always_comb begin
        if (paddr[2] == REG_QUAL) begin
            prdata = {{(PDATA_W-8){1'b0}}, r_qual_thr};
        end else begin
            prdata = {{(PDATA_W-1){1'b0}}, r_invert_x};
        end
    end

    assign o_qual_thr = r_qual_thr;
    assign o_invert_x = r_invert_x;

endmodule

@@ rtl/ofa_frame_buf.sv @@
// Frame byte store with saturating byte counter.
module ofa_frame_buf (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_wr,
    input  logic            i_eof,
    input  logic [7:0]      i_byte,
    output ofa_pkg::t_frame o_frame,
    output logic            o_full
);
    import ofa_pkg::*;

    logic [CNT_W-1:0] r_count;
    t_frame           r_frame;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_eof) begin
            r_count <= '0;
        end else if (i_wr && (r_count <= CNT_W'(FRAME_LEN))) begin
            r_count <= r_count + CNT_W'(1);
        end
    end

    for (genvar g = 0; g < FRAME_LEN; g++) begin : g_byte
        always_ff @(posedge i_clk) begin
            if (i_wr && (r_count == CNT_W'(g))) begin
                r_frame[g] <= i_byte;
            end
        end
    end

    assign o_frame = r_frame;
    assign o_full  = (r_count == CNT_W'(FRAME_LEN));

endmodule

@@ rtl/ofa_frame_check.sv @@
// Frame validation and delta extraction.
module ofa_frame_check (
    input  ofa_pkg::t_frame     i_frame,
    input  logic                i_full,
    input  logic [7:0]          i_qual_thr,
    input  logic                i_invert_x,
    output ofa_pkg::t_check_res o_res
);
    import ofa_pkg::*;

    logic [7:0]      sum;
    logic [DX_W-1:0] dx_ext;
    logic            bad_frame;

    assign bad_frame = !i_full || (i_frame[0] != HEADER_BYTE)
                       || (i_frame[FRAME_LEN-1] != TAIL_BYTE);
    assign sum    = i_frame[2] + i_frame[3] + i_frame[4] + i_frame[5];
    assign dx_ext = {i_frame[3][7], i_frame[3], i_frame[2]};

    always_comb begin
        o_res.dx     = i_invert_x ? -dx_ext : dx_ext;
        o_res.dy     = {i_frame[5], i_frame[4]};
        o_res.accept = 1'b0;
        priority if (bad_frame) begin
            o_res.status = ST_BAD_FRAME;
        end else if (sum != i_frame[6]) begin
            o_res.status = ST_BAD_SUM;
        end else if (i_frame[7] <= i_qual_thr) begin
            o_res.status = ST_LOW_QUAL;
        end else begin
            o_res.status = ST_OK;
            o_res.accept = 1'b1;
        end
    end

endmodule

@@ rtl/ofa_checker.sv @@
// Port-level assertions for the accumulator core, bound to the top level.
module ofa_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_in_valid,
    input logic                             o_in_ready,
    input logic                             o_out_valid,
    input logic                             i_out_ready,
    input logic signed [ofa_pkg::POS_W-1:0] o_pos_x,
    input logic signed [ofa_pkg::POS_W-1:0] o_pos_y,
    input logic signed [ofa_pkg::DX_W-1:0]  o_delta_x,
    input logic signed [ofa_pkg::DY_W-1:0]  o_delta_y,
    input logic [2:0]                       o_status
);
    import ofa_pkg::*;

    logic [1:0]      r_occ;
    logic [DX_W-1:0] r_last_dx;
    logic [DY_W-1:0] r_last_dy;
    logic            in_acc, out_acc;

    assign in_acc  = i_in_valid && o_in_ready;
    assign out_acc = o_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ     <= '0;
            r_last_dx <= '0;
            r_last_dy <= '0;
        end else begin
            r_occ <= r_occ + {1'b0, in_acc} - {1'b0, out_acc};
            if (out_acc) begin
                r_last_dx <= o_delta_x;
                r_last_dy <= o_delta_y;
            end
        end
    end

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_pos_x)
            && $stable(o_pos_y) && $stable(o_status))
        else $error("result changed while stalled");

    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= 2'd2)
        else $error("more than two requests in flight");

    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ == 2'd0 |-> o_in_ready && !o_out_valid)
        else $error("empty core not ready or showing a result");

    a_delta_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status != ST_OK) |->
            (o_delta_x == r_last_dx) && (o_delta_y == r_last_dy))
        else $error("deltas changed without an accepted frame");

endmodule

bind optical_flow_frame_accumulator_core ofa_checker u_ofa_checker (.*);
